### sv/msmt_pkg.sv
`timescale 1ns / 1ps

package msmt_pkg;

    // fixed field widths of the request and response channels
    localparam int MODE_W    = 2;
    localparam int MASK_IN_W = 32;
    localparam int HANDLE_W  = 16;
    localparam int STATUS_W  = 3;
    localparam int RCOUNT_W  = 6;

    // request operation codes
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_FULL    = 3'd1,
        ST_REMOVED = 3'd2,
        ST_MATCH   = 3'd3,
        ST_NOMATCH = 3'd4
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic add_commit;
        logic scan;
        logic finish;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic slot_free;
        logic scan_done;
    } t_sts;

endpackage

### sv/msmt_if.sv
`timescale 1ns / 1ps

// request channel
interface msmt_req_if;
    logic                           valid;
    logic                           ready;
    logic [msmt_pkg::MODE_W-1:0]    mode;
    logic [msmt_pkg::MASK_IN_W-1:0] mask;
    logic [msmt_pkg::HANDLE_W-1:0]  handle;

    modport source (output valid, mode, mask, handle, input ready);
    modport sink   (input valid, mode, mask, handle, output ready);
endinterface

// response channel
interface msmt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [msmt_pkg::STATUS_W-1:0] status;
    logic [msmt_pkg::HANDLE_W-1:0] match_handle;
    logic [msmt_pkg::RCOUNT_W-1:0] removed_count;
    logic                          last;

    modport source (output valid, status, match_handle, removed_count, last, input ready);
    modport sink   (input valid, status, match_handle, removed_count, last, output ready);
endinterface

### sv/msmt_ram.sv
`timescale 1ns / 1ps

module msmt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/msmt_ctrl.sv
`timescale 1ns / 1ps

module msmt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic [msmt_pkg::MODE_W-1:0] i_req_mode,
    output logic                        o_req_ready,
    input  msmt_pkg::t_sts              i_sts,
    output msmt_pkg::t_cmd              o_cmd
);

    msmt_pkg::t_state r_state;
    msmt_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msmt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            msmt_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_req_mode)
                        msmt_pkg::MODE_ADD:    n_state = msmt_pkg::S_ADD;
                        msmt_pkg::MODE_REMOVE: n_state = msmt_pkg::S_SCAN;
                        msmt_pkg::MODE_QUERY:  n_state = msmt_pkg::S_SCAN;
                        // unused code: dropped with no response
                        default:               n_state = msmt_pkg::S_IDLE;
                    endcase
                end
            end
            msmt_pkg::S_ADD: begin
                if (i_sts.slot_free) begin
                    o_cmd.add_commit = 1'b1;
                    n_state          = msmt_pkg::S_IDLE;
                end
            end
            msmt_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = msmt_pkg::S_DONE;
                end
            end
            msmt_pkg::S_DONE: begin
                if (i_sts.slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = msmt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = msmt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### sv/msmt_dp.sv
`timescale 1ns / 1ps

module msmt_dp #(
    parameter int TABLE_DEPTH = 32,
    parameter int MASK_BITS   = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  msmt_pkg::t_cmd                  i_cmd,
    output msmt_pkg::t_sts                  o_sts,
    input  logic [msmt_pkg::MODE_W-1:0]     i_mode,
    input  logic [msmt_pkg::MASK_IN_W-1:0]  i_mask,
    input  logic [msmt_pkg::HANDLE_W-1:0]   i_handle,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [msmt_pkg::STATUS_W-1:0]   o_status,
    output logic [msmt_pkg::HANDLE_W-1:0]   o_match_handle,
    output logic [msmt_pkg::RCOUNT_W-1:0]   o_removed_count,
    output logic                            o_last
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int HW = msmt_pkg::HANDLE_W;
    localparam int EW = MASK_BITS + HW;

    // request registers
    logic [msmt_pkg::MODE_W-1:0] r_req_mode;
    logic [MASK_BITS-1:0]        r_req_mask;
    logic [HW-1:0]               r_req_handle;

    // table occupancy and scan state
    logic [CW-1:0] r_count,   n_count;
    logic [CW-1:0] r_rd_idx,  n_rd_idx;
    logic [CW-1:0] r_wr_idx,  n_wr_idx;
    logic [CW-1:0] r_rm_cnt,  n_rm_cnt;
    logic          r_ev_vld,  n_ev_vld;
    logic          r_pend_vld, n_pend_vld;
    logic [HW-1:0] r_pend_handle, n_pend_handle;

    // response register
    logic             r_out_vld, n_out_vld;
    msmt_pkg::t_status r_out_status, n_out_status;
    logic [HW-1:0]    r_out_handle, n_out_handle;
    logic [CW-1:0]    r_out_rm, n_out_rm;
    logic             r_out_last, n_out_last;

    // table memory
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          rd_en;
    logic [EW-1:0] rd_data;

    logic [MASK_BITS-1:0] ent_mask;
    logic [HW-1:0]        ent_handle;
    logic                 is_query;
    logic                 is_remove;
    logic                 full;
    logic                 slot_free;
    logic                 hit;
    logic                 stall;
    logic                 advance;
    logic                 eval;

    msmt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // scan pipeline control
    always_comb begin
        ent_mask   = rd_data[EW-1:HW];
        ent_handle = rd_data[HW-1:0];
        is_query   = (r_req_mode == msmt_pkg::MODE_QUERY);
        is_remove  = (r_req_mode == msmt_pkg::MODE_REMOVE);
        full       = (r_count == CW'(TABLE_DEPTH));
        slot_free  = !r_out_vld || i_out_ready;
        hit        = ((ent_mask & r_req_mask) == r_req_mask);
        // a new match must flush the held one, which needs a free response slot
        stall      = i_cmd.scan && r_ev_vld && is_query && hit && r_pend_vld && !slot_free;
        advance    = i_cmd.scan && !stall;
        rd_en      = advance && (r_rd_idx != r_count);
        eval       = advance && r_ev_vld;

        o_sts.slot_free = slot_free;
        o_sts.scan_done = !r_ev_vld && (r_rd_idx == r_count);
    end

    // table writes: append on add, compaction on remove
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wr_idx[AW-1:0];
        wr_data = rd_data;
        if (i_cmd.add_commit && !full) begin
            wr_en   = 1'b1;
            wr_addr = r_count[AW-1:0];
            wr_data = {r_req_mask, r_req_handle};
        end else if (eval && is_remove && (ent_handle != r_req_handle)) begin
            wr_en = 1'b1;
        end
    end

    // next values of scan state and response
    always_comb begin
        n_count       = r_count;
        n_rd_idx      = r_rd_idx;
        n_wr_idx      = r_wr_idx;
        n_rm_cnt      = r_rm_cnt;
        n_ev_vld      = r_ev_vld;
        n_pend_vld    = r_pend_vld;
        n_pend_handle = r_pend_handle;
        n_out_vld     = r_out_vld && !i_out_ready;
        n_out_status  = r_out_status;
        n_out_handle  = r_out_handle;
        n_out_rm      = r_out_rm;
        n_out_last    = r_out_last;

        if (i_cmd.load) begin
            n_rd_idx   = '0;
            n_wr_idx   = '0;
            n_rm_cnt   = '0;
            n_ev_vld   = 1'b0;
            n_pend_vld = 1'b0;
        end

        // add result
        if (i_cmd.add_commit) begin
            n_out_vld    = 1'b1;
            n_out_status = full ? msmt_pkg::ST_FULL : msmt_pkg::ST_ADDED;
            n_out_handle = '0;
            n_out_rm     = '0;
            n_out_last   = 1'b1;
            if (!full) begin
                n_count = r_count + CW'(1);
            end
        end

        // one table entry per cycle while the scan is not stalled
        if (advance) begin
            n_ev_vld = rd_en;
            if (rd_en) begin
                n_rd_idx = r_rd_idx + CW'(1);
            end
        end

        if (eval) begin
            if (is_remove) begin
                if (ent_handle == r_req_handle) begin
                    n_rm_cnt = r_rm_cnt + CW'(1);
                end else begin
                    n_wr_idx = r_wr_idx + CW'(1);
                end
            end else if (is_query && hit) begin
                // hold the newest match so the final one can carry last
                if (r_pend_vld) begin
                    n_out_vld    = 1'b1;
                    n_out_status = msmt_pkg::ST_MATCH;
                    n_out_handle = r_pend_handle;
                    n_out_rm     = '0;
                    n_out_last   = 1'b0;
                end
                n_pend_vld    = 1'b1;
                n_pend_handle = ent_handle;
            end
        end

        // closing result of a remove or query
        if (i_cmd.finish) begin
            n_out_vld  = 1'b1;
            n_out_last = 1'b1;
            n_out_rm   = '0;
            n_out_handle = '0;
            if (is_remove) begin
                n_out_status = msmt_pkg::ST_REMOVED;
                n_out_rm     = r_rm_cnt;
                n_count      = r_wr_idx;
            end else if (r_pend_vld) begin
                n_out_status = msmt_pkg::ST_MATCH;
                n_out_handle = r_pend_handle;
            end else begin
                n_out_status = msmt_pkg::ST_NOMATCH;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_ev_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_ev_vld   <= n_ev_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_mode   <= i_mode;
            r_req_mask   <= MASK_BITS'(i_mask);
            r_req_handle <= i_handle;
        end
        r_rd_idx      <= n_rd_idx;
        r_wr_idx      <= n_wr_idx;
        r_rm_cnt      <= n_rm_cnt;
        r_pend_handle <= n_pend_handle;
        r_out_status  <= n_out_status;
        r_out_handle  <= n_out_handle;
        r_out_rm      <= n_out_rm;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out_status;
    assign o_match_handle  = r_out_handle;
    assign o_removed_count = msmt_pkg::RCOUNT_W'(r_out_rm);
    assign o_last          = r_out_last;

endmodule

### sv/mask_subset_match_table.sv
`timescale 1ns / 1ps

// Ordered table of (mask, handle) entries held in a single-port-read RAM. Requests are
// handled one at a time. An add is committed once the response register is free, and its
// response is registered. A remove or a query walks the table through the RAM read port at
// one entry per cycle while the response channel does not hold back a match; the remove
// compacts survivors in place during the same walk. Query responses arrive in insertion
// order, each match held back until the next one is found so the final one carries last.
// A new request is taken while the previous response still waits on the output register.
// Mode 3 is taken and dropped without a response. No clearing pass follows reset.
module mask_subset_match_table #(
    parameter int TABLE_DEPTH = 32,
    parameter int MASK_BITS   = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msmt_req_if.sink   i_req,
    msmt_rsp_if.source o_rsp
);

    msmt_pkg::t_cmd cmd;
    msmt_pkg::t_sts sts;

    msmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_mode  (i_req.mode),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    msmt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MASK_BITS   (MASK_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_req.mode),
        .i_mask          (i_req.mask),
        .i_handle        (i_req.handle),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_status        (o_rsp.status),
        .o_match_handle  (o_rsp.match_handle),
        .o_removed_count (o_rsp.removed_count),
        .o_last          (o_rsp.last)
    );

    // single-response requests always close with last
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == msmt_pkg::ST_NOMATCH ||
                         o_rsp.status == msmt_pkg::ST_REMOVED ||
                         o_rsp.status == msmt_pkg::ST_ADDED ||
                         o_rsp.status == msmt_pkg::ST_FULL)) |-> o_rsp.last)
        else $error("non-match response without last");

    // handle field is zero except on a match
    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != msmt_pkg::ST_MATCH) |-> (o_rsp.match_handle == '0))
        else $error("handle set on non-match response");

    // an accepted add, remove or query keeps the block busy on the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.mode == msmt_pkg::MODE_ADD ||
                                        i_req.mode == msmt_pkg::MODE_REMOVE ||
                                        i_req.mode == msmt_pkg::MODE_QUERY))
        |=> !i_req.ready)
        else $error("request taken while previous one in progress");

endmodule

### tb/msmt_table_checker.sv
`timescale 1ns / 1ps

// watches both channels, keeps its own copy of the table and checks every response transfer
module msmt_table_checker
    import msmt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int MASK_BITS   = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    msmt_req_if  i_req,
    msmt_rsp_if  i_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_seen,
    output int   o_longest_burst
);

    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        t_status               status;
        logic [HANDLE_W-1:0]   match_handle;
        logic [RCOUNT_W-1:0]   removed_count;
        logic                  last;
    } t_rsp_item;

    // shadow table
    logic [MASK_BITS-1:0] tbl_mask   [TABLE_DEPTH];
    logic [HANDLE_W-1:0]  tbl_handle [TABLE_DEPTH];
    int                   tbl_count;

    // responses still owed by the block, oldest first
    t_rsp_item            owed_rsp [$];
    int                   match_run;

    function automatic t_rsp_item rsp_item(t_status st, logic [HANDLE_W-1:0] h,
                                           logic [RCOUNT_W-1:0] n, logic l);
        t_rsp_item r;
        r.status        = st;
        r.match_handle  = h;
        r.removed_count = n;
        r.last          = l;
        return r;
    endfunction

    // queue one owed response behind the others
    function automatic void owe(t_rsp_item r);
        owed_rsp.insert(owed_rsp.size(), r);
    endfunction

    // update the shadow table for one request and queue the responses it causes
    function automatic void apply_request(logic [MODE_W-1:0] mode, logic [MASK_IN_W-1:0] mask_in,
                                          logic [HANDLE_W-1:0] handle);
        logic [MASK_BITS-1:0] want;
        int keep;
        int dropped;
        int last_hit;
        want = MASK_BITS'(mask_in);
        case (mode)
            MODE_ADD: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    owe(rsp_item(ST_FULL, '0, '0, 1'b1));
                end else begin
                    tbl_mask[tbl_count]   = want;
                    tbl_handle[tbl_count] = handle;
                    tbl_count++;
                    owe(rsp_item(ST_ADDED, '0, '0, 1'b1));
                end
            end
            MODE_REMOVE: begin
                // drop matching handles, survivors slide down in order
                keep    = 0;
                dropped = 0;
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_handle[i] == handle) begin
                        dropped++;
                    end else begin
                        tbl_mask[keep]   = tbl_mask[i];
                        tbl_handle[keep] = tbl_handle[i];
                        keep++;
                    end
                end
                tbl_count = keep;
                owe(rsp_item(ST_REMOVED, '0, RCOUNT_W'(dropped), 1'b1));
            end
            MODE_QUERY: begin
                last_hit = -1;
                for (int i = 0; i < tbl_count; i++) begin
                    if ((tbl_mask[i] & want) == want) last_hit = i;
                end
                if (last_hit < 0) begin
                    owe(rsp_item(ST_NOMATCH, '0, '0, 1'b1));
                end else begin
                    for (int i = 0; i <= last_hit; i++) begin
                        if ((tbl_mask[i] & want) == want) begin
                            owe(rsp_item(ST_MATCH, tbl_handle[i], '0,
                                         logic'(i == last_hit)));
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // responses are checked before the request of the same edge is predicted
    always @(posedge i_clk) begin : watch
        t_rsp_item got;
        t_rsp_item want;
        if (!i_rst_n) begin
            tbl_count = 0;
            match_run = 0;
            owed_rsp.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.status        = t_status'(i_rsp.status);
                got.match_handle  = i_rsp.match_handle;
                got.removed_count = i_rsp.removed_count;
                got.last          = i_rsp.last;
                if (owed_rsp.size() == 0) begin
                    o_errors++;
                    if (o_errors <= MAX_REPORTS)
                        $display("%0t: unexpected response ", $time,
                                 "status=%0d handle=%h removed=%0d last=%b",
                                 got.status, got.match_handle, got.removed_count,
                                 got.last);
                end else begin
                    want = owed_rsp.pop_front();
                    o_checked++;
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= MAX_REPORTS)
                            $display("%0t: response mismatch, ", $time,
                                     "expected status=%0d handle=%h removed=%0d last=%b, ",
                                     want.status, want.match_handle,
                                     want.removed_count, want.last,
                                     "got status=%0d handle=%h removed=%0d last=%b",
                                     got.status, got.match_handle, got.removed_count,
                                     got.last);
                    end
                end
                // statistics on what came back
                if (got.status == ST_FULL) o_full_seen++;
                if (got.status == ST_MATCH) match_run++;
                if (got.last) begin
                    if (match_run > o_longest_burst) o_longest_burst = match_run;
                    match_run = 0;
                end
            end
            if (i_req.valid && i_req.ready)
                apply_request(i_req.mode, i_req.mask, i_req.handle);
        end
        o_pending = owed_rsp.size();
    end

endmodule

### tb/mask_subset_match_table_tb.sv
`timescale 1ns / 1ps

module mask_subset_match_table_tb;
    import msmt_pkg::*;

    localparam int TABLE_DEPTH  = 32;
    localparam int MASK_BITS    = 32;
    localparam int RANDOM_ITEMS = 420;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 48;
    localparam int LIMIT_CYCLES = 3_000_000;

    // mode code the block accepts and drops
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;

    int errors;
    int pending;
    int checked;
    int full_seen;
    int longest_burst;

    int items_sent;
    int hold_requests;
    bit tx_calm;

    logic [HANDLE_W-1:0] handle_pool [8];

    msmt_req_if req_ch ();
    msmt_rsp_if rsp_ch ();

    mask_subset_match_table #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .MASK_BITS  (MASK_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    msmt_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .MASK_BITS  (MASK_BITS)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req_ch),
        .i_rsp          (rsp_ch),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_full_seen    (full_seen),
        .o_longest_burst(longest_burst)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("%0t: run limit of %0d cycles reached", $time, LIMIT_CYCLES);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 4) == 0) return HANDLE_W'($urandom());
        return handle_pool[$urandom_range(0, 7)];
    endfunction

    // stored masks lean dense so that queries find subsets
    function automatic logic [MASK_IN_W-1:0] entry_mask_pick();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return '1;
            3:       return '0;
            4, 5, 6: return $urandom() | $urandom();
            default: return $urandom() | $urandom() | $urandom();
        endcase
    endfunction

    // query masks lean sparse
    function automatic logic [MASK_IN_W-1:0] query_mask_pick();
        case ($urandom_range(0, 7))
            0:       return '0;
            1, 2:    return MASK_IN_W'(1) << $urandom_range(0, MASK_IN_W - 1);
            3:       return (MASK_IN_W'(1) << $urandom_range(0, MASK_IN_W - 1))
                            | (MASK_IN_W'(1) << $urandom_range(0, MASK_IN_W - 1));
            4, 5:    return $urandom() & $urandom() & $urandom();
            6:       return $urandom();
            default: return '1;
        endcase
    endfunction

    // one request transfer; entered and left just after a falling edge
    task automatic send_req(input logic [MODE_W-1:0] mode, input logic [MASK_IN_W-1:0] mask,
                            input logic [HANDLE_W-1:0] handle);
        int gap;
        gap = 0;
        if (!tx_calm && $urandom_range(0, 2) == 0) gap = idle_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.mode   <= mode;
        req_ch.mask   <= mask;
        req_ch.handle <= handle;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        if (mode != MODE_UNUSED) items_sent++;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
    endtask

    // pushes the table past full, one handle for all or a mix
    task automatic fill_table(input logic [HANDLE_W-1:0] h, input bit one_handle);
        repeat (TABLE_DEPTH + 2)
            send_req(MODE_ADD, entry_mask_pick(), one_handle ? h : pick_handle());
    endtask

    // response side: random stalls in busy stretches, free stretches, one long hold
    initial begin : rsp_sink
        int stall_left;
        int stretch_left;
        int holds_served;
        bit calm;
        stall_left   = 0;
        stretch_left = 0;
        holds_served = 0;
        calm         = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n) begin
                if (stretch_left == 0) begin
                    calm         = ($urandom_range(0, 3) == 0);
                    stretch_left = $urandom_range(50, 300);
                end
                stretch_left--;
                if (holds_served != hold_requests) begin
                    holds_served = hold_requests;
                    stall_left   = LONG_HOLD;
                end
                if (stall_left > 0) begin
                    rsp_ch.ready <= 1'b0;
                    stall_left--;
                end else begin
                    rsp_ch.ready <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
                end
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int target;
        int pick;
        int n;
        bit hold_done;
        bit pause_done;
        logic [HANDLE_W-1:0] fill_handle;

        i_rst_n       = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.mode   = MODE_ADD;
        req_ch.mask   = '0;
        req_ch.handle = '0;
        items_sent    = 0;
        hold_requests = 0;
        tx_calm       = 1'b0;
        hold_done     = 1'b0;
        pause_done    = 1'b0;

        handle_pool[0] = '0;
        handle_pool[1] = '1;
        for (int i = 2; i < 8; i++) handle_pool[i] = HANDLE_W'($urandom());

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, unused mode, extremes, duplicates, removal cases
        send_req(MODE_QUERY, '0, '0);
        send_req(MODE_QUERY, '1, '1);
        send_req(MODE_REMOVE, '0, '0);
        send_req(MODE_UNUSED, '1, '1);
        send_req(MODE_ADD, '1, '1);
        send_req(MODE_ADD, '0, '0);
        send_req(MODE_ADD, 32'hA5A5_A5A5, 16'h1234);
        send_req(MODE_ADD, '1, '1);
        send_req(MODE_ADD, 32'h5A5A_5A5A, 16'hBEEF);
        send_req(MODE_QUERY, '0, 16'hFFFF);
        send_req(MODE_QUERY, '1, '0);
        send_req(MODE_QUERY, 32'h8000_0001, '0);
        send_req(MODE_QUERY, 32'h5A00_0000, '0);
        send_req(MODE_UNUSED, '0, '0);
        send_req(MODE_REMOVE, '1, '1);
        send_req(MODE_REMOVE, '0, 16'h5555);
        send_req(MODE_QUERY, '0, '0);
        send_req(MODE_REMOVE, '0, '0);
        send_req(MODE_QUERY, '1, '0);
        send_req(MODE_REMOVE, '0, 16'h1234);
        send_req(MODE_REMOVE, '0, 16'hBEEF);
        req_ch.valid <= 1'b0;
        wait_drained();

        // full table of one handle: full reports, longest query, largest remove
        target      = items_sent + RANDOM_ITEMS;
        fill_handle = pick_handle();
        fill_table(fill_handle, 1'b1);
        send_req(MODE_QUERY, '0, HANDLE_W'($urandom()));
        send_req(MODE_QUERY, query_mask_pick(), HANDLE_W'($urandom()));
        send_req(MODE_REMOVE, $urandom(), fill_handle);

        // random mix of well-formed traffic with some unused-mode noise
        while (items_sent < target) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            if (!hold_done && items_sent >= target - 280) begin
                hold_requests++;
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent >= target - 140) begin
                req_ch.valid <= 1'b0;
                wait_drained();
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                n = $urandom_range(1, 6);
                repeat (n) send_req(MODE_ADD, entry_mask_pick(), pick_handle());
            end else if (pick < 55) begin
                n = $urandom_range(1, 3);
                repeat (n) send_req(MODE_QUERY, query_mask_pick(), HANDLE_W'($urandom()));
            end else if (pick < 70) begin
                send_req(MODE_REMOVE, $urandom(), handle_pool[$urandom_range(0, 7)]);
            end else if (pick < 80) begin
                send_req(MODE_QUERY, '0, HANDLE_W'($urandom()));
            end else if (pick < 87) begin
                send_req(MODE_REMOVE, $urandom(), HANDLE_W'($urandom()));
            end else if (pick < 95) begin
                send_req(MODE_UNUSED, $urandom(), HANDLE_W'($urandom()));
            end else begin
                fill_table(pick_handle(), $urandom_range(0, 1) == 1);
                send_req(MODE_QUERY, '0, HANDLE_W'($urandom()));
            end
        end
        req_ch.valid <= 1'b0;

        // let the last responses come back, then watch for strays
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("run: %0d requests (adds, removes, queries), %0d responses checked",
                 items_sent, checked);
        $display("run: %0d table-full responses, longest match burst %0d",
                 full_seen, longest_burst);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
